[rtl/palette_nearest_color_search_macros.svh]
// assertion helpers, clocked on clk and disabled in reset
`ifndef PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH
`define PALETTE_NEAREST_COLOR_SEARCH_MACROS_SVH

// same-cycle implication
`define PNCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("palette search assertion failed");

// next-cycle implication
`define PNCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("palette search assertion failed");

`endif

[rtl/pncs_pkg.sv]
package pncs_pkg;

	localparam int PALETTE_ENTRIES = 256;
	localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
	localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);
	localparam int CHAN_W          = 6;
	localparam int ENTRY_W         = 3 * CHAN_W;
	localparam int DIST_W          = 14;
	localparam int BEST_W          = 15;

	localparam logic [BEST_W-1:0] BEST_INIT = 15'd30000;
	localparam logic [DIST_W-1:0] MAX_SAD   = 14'd189;
	localparam logic [DIST_W-1:0] MAX_SSD   = 14'd11907;

	localparam logic METRIC_SAD = 1'b0;
	localparam logic METRIC_SSD = 1'b1;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

endpackage

[rtl/pncs_ram.sv]
module pncs_ram #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/pncs_dist.sv]
module pncs_dist import pncs_pkg::*; (
	input  rgb_t              entry,
	input  rgb_t              query,
	input  logic              metric,
	output logic [DIST_W-1:0] distance
);

	function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	logic [CHAN_W-1:0]   dr, dg, db;
	logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
	logic [DIST_W-1:0]   sad, ssd;

	always_comb begin
		dr       = abs_diff(entry.red, query.red);
		dg       = abs_diff(entry.green, query.green);
		db       = abs_diff(entry.blue, query.blue);
		sq_r     = (2*CHAN_W)'(dr) * (2*CHAN_W)'(dr);
		sq_g     = (2*CHAN_W)'(dg) * (2*CHAN_W)'(dg);
		sq_b     = (2*CHAN_W)'(db) * (2*CHAN_W)'(db);
		sad      = DIST_W'(dr) + DIST_W'(dg) + DIST_W'(db);
		ssd      = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
		distance = (metric == METRIC_SSD) ? ssd : sad;
	end

endmodule

[rtl/palette_nearest_color_search.sv]
// Nearest palette color search. A write word (tuser low) stores one RGB palette entry with 6-bit
// channels; writes to an index at or above PALETTE_ENTRIES are dropped. A search word (tuser
// high) walks the whole palette through a single RAM read port and one shared distance unit,
// one entry per cycle, and holds s_tready low until the result is loaded into the output
// register; it returns the lowest index at minimum distance along with that distance.
// The result sits in an output register, so palette writes are taken while it waits. cfg_data
// selects sum of absolute (0) or squared (1) channel differences. Unwritten entries read as black.
`include "palette_nearest_color_search_macros.svh"

module palette_nearest_color_search import pncs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entry_index, red, green, blue, zero pad
	input  logic        s_tuser,  // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // match_index, match_distance, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic                 metric_q;
	logic [PALETTE_ENTRIES-1:0] valid_q;
	rgb_t                 query_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [BEST_W-1:0]    best_dist_q;
	logic                 m_tvalid_q;
	logic [7:0]           out_idx_q;
	logic [DIST_W-1:0]    out_dist_q;

	logic                 vld_s1, vld_s2;
	logic                 ok_s1;
	logic [IDX_W-1:0]     idx_s1, idx_s2;
	logic [DIST_W-1:0]    dist_s2;

	logic [7:0]           in_index;
	rgb_t                 in_rgb;
	logic                 accept, wr_go, srch_go;
	logic                 issue, scan_done;
	logic [IDX_W-1:0]     rd_addr;
	logic [ENTRY_W-1:0]   ram_rdata;
	rgb_t                 entry_s1;
	logic [DIST_W-1:0]    dist_c;
	logic                 better;

	assign in_index     = s_tdata[7:0];
	assign in_rgb.red   = s_tdata[13:8];
	assign in_rgb.green = s_tdata[19:14];
	assign in_rgb.blue  = s_tdata[25:20];

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = s_tvalid && s_tready;
	assign wr_go     = accept && (s_tuser == CMD_WRITE)
		&& (9'(in_index) < 9'(PALETTE_ENTRIES));
	assign srch_go   = accept && (s_tuser == CMD_SEARCH);

	assign rd_addr   = cnt_q[IDX_W-1:0];
	assign issue     = (state_q == ST_SCAN) && (cnt_q != CNT_W'(PALETTE_ENTRIES));
	assign scan_done = (state_q == ST_SCAN) && !issue && !vld_s1 && !vld_s2;

	pncs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_go),
		.waddr (in_index[IDX_W-1:0]),
		.wdata (in_rgb),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign entry_s1 = ok_s1 ? rgb_t'(ram_rdata) : '0;

	pncs_dist u_dist (
		.entry    (entry_s1),
		.query    (query_q),
		.metric   (metric_q),
		.distance (dist_c)
	);

	assign better = vld_s2 && (BEST_W'(dist_s2) < best_dist_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q <= METRIC_SAD;
			valid_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				metric_q <= cfg_data;
			end
			if (wr_go) begin
				valid_q[in_index[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	// read and distance pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_addr;
		ok_s1   <= valid_q[rd_addr];
		idx_s2  <= idx_s1;
		dist_s2 <= dist_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			best_idx_q  <= '0;
			best_dist_q <= BEST_INIT;
			query_q     <= '0;
			m_tvalid_q  <= 1'b0;
			out_idx_q   <= '0;
			out_dist_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_FINISH)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (srch_go) begin
						state_q     <= ST_SCAN;
						cnt_q       <= '0;
						best_idx_q  <= '0;
						best_dist_q <= BEST_INIT;
						query_q     <= in_rgb;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (better) begin
						best_idx_q  <= idx_s2;
						best_dist_q <= BEST_W'(dist_s2);
					end
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						out_idx_q  <= 8'(best_idx_q);
						out_dist_q <= best_dist_q[DIST_W-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, out_dist_q, out_idx_q};

	`PNCS_ASSERT_NEXT(a_busy_after_search, srch_go, !s_tready)
	`PNCS_ASSERT_NOW(a_match_found, state_q == ST_FINISH, best_dist_q < BEST_INIT)
	`PNCS_ASSERT_NOW(a_sad_range, m_tvalid && (metric_q == METRIC_SAD), m_tdata[21:8] <= MAX_SAD)
	`PNCS_ASSERT_NOW(a_ssd_range, m_tvalid, m_tdata[21:8] <= MAX_SSD)

endmodule
